[rtl/core/afd_pkg.sv]
package afd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned FTYPE_W  = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned KIND_W   = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_TYPE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // Frame end status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADSUM  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZEROLEN = 2'd3;

  // Frame type bytes and their codes
  localparam logic [BYTE_W-1:0] TB_TX_STATUS    = 8'h89;
  localparam logic [BYTE_W-1:0] TB_ZB_TX_STATUS = 8'h8B;
  localparam logic [BYTE_W-1:0] TB_RX64         = 8'h80;
  localparam logic [BYTE_W-1:0] TB_RX16         = 8'h81;
  localparam logic [BYTE_W-1:0] TB_ZB_RECEIVE   = 8'h90;

  localparam logic [FTYPE_W-1:0] FT_TX_STATUS    = 3'd0;
  localparam logic [FTYPE_W-1:0] FT_ZB_TX_STATUS = 3'd1;
  localparam logic [FTYPE_W-1:0] FT_RX64         = 3'd2;
  localparam logic [FTYPE_W-1:0] FT_RX16         = 3'd3;
  localparam logic [FTYPE_W-1:0] FT_ZB_RECEIVE   = 3'd4;

  localparam logic [BYTE_W-1:0] SUM_GOOD = 8'hFF;

  // Work handed from the parser to the result stage
  typedef enum logic [1:0] {
    CMD_TYPE,   // report type, load checksum with the byte
    CMD_DATA,   // pass payload byte, add it to the checksum
    CMD_CHECK,  // add checksum byte, report end with sum status
    CMD_END     // report end with the given status
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [BYTE_W-1:0]    data;
    logic [INDEX_W-1:0]   idx;
    logic [FTYPE_W-1:0]   ftype;
    logic [STATUS_W-1:0]  status;
  } cmd_t;

  typedef struct packed {
    logic               known;
    logic [FTYPE_W-1:0] code;
  } type_map_t;

  function automatic type_map_t map_type(input logic [BYTE_W-1:0] b);
    type_map_t m;
    m.known = 1'b1;
    m.code  = FT_TX_STATUS;
    unique case (b)
      TB_TX_STATUS:    m.code = FT_TX_STATUS;
      TB_ZB_TX_STATUS: m.code = FT_ZB_TX_STATUS;
      TB_RX64:         m.code = FT_RX64;
      TB_RX16:         m.code = FT_RX16;
      TB_ZB_RECEIVE:   m.code = FT_ZB_RECEIVE;
      default:         m.known = 1'b0;
    endcase
    return m;
  endfunction

endpackage

[rtl/core/api_frame_deframer.sv]
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0] rx_byte
// m_*       out  m_tvalid/m_tready  m_tuser result_kind, m_tdata packed result fields
// cfg_*     in   cfg_we             cfg_data start of frame byte
//
// One byte per cycle while the command queue has room; the parser decides each byte
// combinationally. A result reaches m_* after its byte's transfer through the queue
// write, then the output register.
// Reset (rst, synchronous) returns to hunting, empties the queue, delimiter = 0x7E.
// A stalled m_tready fills the command queue; s_tready drops only when it is full.
// Bytes that give no result (hunting, length bytes) are taken whenever s_tready is high.
module api_frame_deframer import afd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // result stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] data_byte, [23:8] byte_index,
                                 // [26:24] frame_type, [28:27] frame_status, [31:29] zero
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  // delimiter register write
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);

  logic [BYTE_W-1:0]   delim_value;
  logic                in_fire;
  logic                push;
  cmd_t                push_cmd;
  cmd_t                head;
  logic                q_full, q_empty, pop;
  logic [KIND_W-1:0]   out_kind;
  logic [BYTE_W-1:0]   out_data;
  logic [INDEX_W-1:0]  out_idx;
  logic [FTYPE_W-1:0]  out_ftype;
  logic [STATUS_W-1:0] out_status;

  // Hold the delimiter; a change takes effect at the next hunt.
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_value <= 8'h7E;
    end else if (cfg_we) begin
      delim_value <= cfg_data;
    end
  end

  // Take a byte whenever the queue has room for the command it may cause.
  assign s_tready = !q_full;
  assign in_fire  = s_tvalid && s_tready;

  // Front: frame parser, classifies each byte into a command.
  afd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_byte   (s_tdata),
    .delimiter (delim_value),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Short command queue decouples the parser from output stalls.
  afd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: checksum accumulation and result register.
  afd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (out_kind),
    .out_data   (out_data),
    .out_idx    (out_idx),
    .out_ftype  (out_ftype),
    .out_status (out_status)
  );

  assign m_tuser = out_kind;
  assign m_tdata = {3'b000, out_status, out_ftype, out_idx, out_data};

  // Never a kind code beyond frame end.
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'd3))
    else $error("illegal result kind");

  // Payload bytes start at index one, after the type byte.
  a_data_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_DATA) |-> (m_tdata[23:8] != 16'd0))
    else $error("payload byte with index zero");

  // Status is only nonzero on frame end results.
  a_status_end_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_END) |-> (m_tdata[28:27] == ST_OK))
    else $error("status on non-end result");

  // Frames without a known type report type zero.
  a_type_cleared: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_END &&
     (m_tdata[28:27] == ST_ZEROLEN || m_tdata[28:27] == ST_UNKNOWN))
    |-> (m_tdata[26:24] == 3'd0))
    else $error("stale frame type on early end");

endmodule

[rtl/core/afd_front.sv]
module afd_front import afd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic [BYTE_W-1:0] delimiter,
  output logic              push,
  output cmd_t              push_cmd
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LENHI,
    PH_LENLO,
    PH_TYPE,
    PH_DATA,
    PH_SUM
  } phase_t;

  phase_t              phase, phase_next;
  logic [INDEX_W-1:0]  frame_length, frame_length_next;
  logic [INDEX_W-1:0]  position, position_next;
  logic [FTYPE_W-1:0]  type_code, type_code_next;
  logic [INDEX_W-1:0]  position_inc;
  logic [INDEX_W-1:0]  length_full;
  type_map_t           tmap;

  assign position_inc = position + INDEX_W'(1);
  assign length_full  = {frame_length[INDEX_W-1:BYTE_W], in_byte};
  assign tmap         = map_type(in_byte);

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    position_next     = position;
    type_code_next    = type_code;
    push              = 1'b0;
    push_cmd.op       = CMD_END;
    push_cmd.data     = in_byte;
    push_cmd.idx      = position;
    push_cmd.ftype    = type_code;
    push_cmd.status   = ST_OK;
    if (in_fire) begin
      unique case (phase)
        PH_HUNT: begin
          if (in_byte == delimiter) begin
            frame_length_next = '0;
            position_next     = '0;
            type_code_next    = '0;
            phase_next        = PH_LENHI;
          end
        end
        PH_LENHI: begin
          frame_length_next = {in_byte, {BYTE_W{1'b0}}};
          phase_next        = PH_LENLO;
        end
        PH_LENLO: begin
          frame_length_next = length_full;
          if (length_full == '0) begin
            push            = 1'b1;
            push_cmd.op     = CMD_END;
            push_cmd.status = ST_ZEROLEN;
            phase_next      = PH_HUNT;
          end else begin
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          push = 1'b1;
          if (!tmap.known) begin
            type_code_next  = '0;
            push_cmd.op     = CMD_END;
            push_cmd.ftype  = '0;
            push_cmd.status = ST_UNKNOWN;
            phase_next      = PH_HUNT;
          end else begin
            type_code_next = tmap.code;
            position_next  = INDEX_W'(1);
            push_cmd.op    = CMD_TYPE;
            push_cmd.ftype = tmap.code;
            phase_next     = (frame_length == INDEX_W'(1)) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          push          = 1'b1;
          push_cmd.op   = CMD_DATA;
          position_next = position_inc;
          if (position_inc >= frame_length) begin
            phase_next = PH_SUM;
          end
        end
        PH_SUM: begin
          push        = 1'b1;
          push_cmd.op = CMD_CHECK;
          phase_next  = PH_HUNT;
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= '0;
      position     <= '0;
      type_code    <= '0;
    end else begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      position     <= position_next;
      type_code    <= type_code_next;
    end
  end

endmodule

[rtl/core/afd_queue.sv]
module afd_queue import afd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wrap_inc(wr_ptr);
      if (do_pop)  rd_ptr <= wrap_inc(rd_ptr);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/afd_back.sv]
module afd_back import afd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_kind,
  output logic [BYTE_W-1:0]   out_data,
  output logic [INDEX_W-1:0]  out_idx,
  output logic [FTYPE_W-1:0]  out_ftype,
  output logic [STATUS_W-1:0] out_status
);

  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] sum_add;

  assign pop     = !empty && (!out_valid || out_ready);
  assign sum_add = running_sum + head.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      running_sum <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        unique case (head.op)
          CMD_TYPE:  running_sum <= head.data;
          CMD_DATA:  running_sum <= sum_add;
          CMD_CHECK: running_sum <= sum_add;
          CMD_END:   running_sum <= running_sum;
        endcase
      end
    end
  end

  // Payload of the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      out_ftype  <= head.ftype;
      out_data   <= '0;
      out_idx    <= '0;
      out_status <= ST_OK;
      unique case (head.op)
        CMD_TYPE: out_kind <= KIND_TYPE;
        CMD_DATA: begin
          out_kind <= KIND_DATA;
          out_data <= head.data;
          out_idx  <= head.idx;
        end
        CMD_CHECK: begin
          out_kind   <= KIND_END;
          out_status <= (sum_add == SUM_GOOD) ? ST_OK : ST_BADSUM;
        end
        CMD_END: begin
          out_kind   <= KIND_END;
          out_status <= head.status;
        end
      endcase
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import afd_pkg::*;

  // Parser position inside a frame, one step per received byte.
  typedef enum logic [2:0] {
    HUNT,
    LEN_HI,
    LEN_LO,
    TYPE_BYTE,
    PAYLOAD,
    CHECKSUM
  } parse_stage_e;

  // One deframer result, fields in the same order as the packed concatenation
  // built from m_tuser and m_tdata in the monitor below.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   data;
    logic [INDEX_W-1:0]  idx;
    logic [FTYPE_W-1:0]  ftype;
    logic [STATUS_W-1:0] status;
  } frame_result_t;

  // Translate a frame type byte into its code; return 0 for an unknown byte.
  function automatic bit decode_type(input logic [7:0] b, output logic [FTYPE_W-1:0] code);
    code = FT_TX_STATUS;
    case (b)
      TB_TX_STATUS:    code = FT_TX_STATUS;
      TB_ZB_TX_STATUS: code = FT_ZB_TX_STATUS;
      TB_RX64:         code = FT_RX64;
      TB_RX16:         code = FT_RX16;
      TB_ZB_RECEIVE:   code = FT_ZB_RECEIVE;
      default:         return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Shadow deframer: tracks the frame parse for every byte transfer taken by
  // the block and holds the results it still owes, oldest first.
  class deframe_tracker;
    logic [7:0]          delimiter;
    parse_stage_e        stage;
    logic [15:0]         frame_len;
    logic [15:0]         pos;
    logic [7:0]          sum;
    logic [FTYPE_W-1:0]  code;
    frame_result_t       awaited[$];
    int                  mismatches;
    int                  checked;
    int                  ends_seen[4];

    function new();
      delimiter  = 8'h7E;
      stage      = HUNT;
      frame_len  = '0;
      pos        = '0;
      sum        = '0;
      code       = FT_TX_STATUS;
      mismatches = 0;
      checked    = 0;
      foreach (ends_seen[i]) ends_seen[i] = 0;
    endfunction

    function void set_delimiter(logic [7:0] v);
      delimiter = v;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void post(logic [KIND_W-1:0] kind, logic [7:0] data, logic [15:0] idx,
                       logic [STATUS_W-1:0] status);
      frame_result_t r;
      r.kind   = kind;
      r.data   = data;
      r.idx    = idx;
      r.ftype  = code;
      r.status = status;
      awaited.push_back(r);
    endfunction

    // Advance the parse by one accepted byte.
    function void take_byte(logic [7:0] b);
      logic [FTYPE_W-1:0] c;
      case (stage)
        HUNT: begin
          // Anything but the delimiter is line noise.
          if (b == delimiter) begin
            frame_len = '0;
            pos       = '0;
            sum       = '0;
            code      = FT_TX_STATUS;
            stage     = LEN_HI;
          end
        end
        LEN_HI: begin
          frame_len = {b, 8'h00};
          stage     = LEN_LO;
        end
        LEN_LO: begin
          frame_len[7:0] = b;
          if (frame_len == 16'd0) begin
            stage = HUNT;
            post(KIND_END, 8'h00, 16'd0, ST_ZEROLEN);
          end else begin
            stage = TYPE_BYTE;
          end
        end
        TYPE_BYTE: begin
          sum = b;
          if (!decode_type(b, c)) begin
            code  = FT_TX_STATUS;
            stage = HUNT;
            post(KIND_END, 8'h00, 16'd0, ST_UNKNOWN);
          end else begin
            code  = c;
            pos   = 16'd1;
            stage = (frame_len == 16'd1) ? CHECKSUM : PAYLOAD;
            post(KIND_TYPE, 8'h00, 16'd0, ST_OK);
          end
        end
        PAYLOAD: begin
          post(KIND_DATA, b, pos, ST_OK);
          sum = sum + b;
          pos = pos + 16'd1;
          if (pos >= frame_len) stage = CHECKSUM;
        end
        default: begin
          sum   = sum + b;
          stage = HUNT;
          post(KIND_END, 8'h00, 16'd0, (sum == SUM_GOOD) ? ST_OK : ST_BADSUM);
        end
      endcase
    endfunction

    function bit field_ok(string name, int unsigned want, int unsigned got);
      if (want == got) return 1'b1;
      if (mismatches < 30)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b0;
    endfunction

    // Compare one result transfer with the oldest owed result.
    function void check_result(frame_result_t got);
      frame_result_t want;
      bit ok;
      if (awaited.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual kind %0d", $time, got.kind);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      // Bitwise AND so every wrong field gets reported.
      ok = field_ok("result_kind", 32'(want.kind), 32'(got.kind)) &
           field_ok("data_byte", 32'(want.data), 32'(got.data)) &
           field_ok("byte_index", 32'(want.idx), 32'(got.idx)) &
           field_ok("frame_type", 32'(want.ftype), 32'(got.ftype)) &
           field_ok("frame_status", 32'(want.status), 32'(got.status));
      if (!ok) mismatches++;
      if (want.kind == KIND_END) ends_seen[want.status]++;
      checked++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;    // [7:0] data_byte, [23:8] byte_index, [26:24] frame_type,
                           // [28:27] frame_status
  logic [1:0]  m_tuser;    // [1:0] result_kind
  logic        cfg_we;
  logic [7:0]  cfg_data;

  deframe_tracker tracker = new();

  // Stimulus bookkeeping
  logic [7:0] byte_stream[$];   // bytes waiting to be sent
  logic [7:0] payload_q[$];     // payload of the next frame being built
  logic [7:0] cur_delim = 8'h7E;
  logic [7:0] known_types[5] = '{TB_TX_STATUS, TB_ZB_TX_STATUS, TB_RX64, TB_RX16,
                                 TB_ZB_RECEIVE};
  logic [7:0] delim_plan[5] = '{8'h00, 8'hFF, 8'h00, 8'h89, 8'h7E};
  int         frame_bytes = 0;  // bytes queued as part of a frame, noise excluded
  bit         tx_steady = 1'b0;
  bit         rx_steady = 1'b0;
  int         stall_left = 0;

  api_frame_deframer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Hard stop in case a transfer never completes.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Sample both streams at the edge; values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.take_byte(s_tdata);
      if (m_tvalid && m_tready)
        tracker.check_result({m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[26:24],
                              m_tdata[28:27]});
    end
  end

  // Result side back-pressure: mostly ready, short stalls, now and then a long one.
  always @(posedge clk) begin
    if (rst || rx_steady) begin
      m_tready <= !rst;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(99) < 70) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= 1'b0;
      stall_left = ($urandom_range(99) < 85) ? $urandom_range(2) : $urandom_range(5, 30);
    end
  end

  function automatic void queue_byte(logic [7:0] b);
    byte_stream.push_back(b);
    frame_bytes++;
  endfunction

  // Noise byte that mostly steers clear of the delimiter.
  function automatic void queue_noise();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == cur_delim && $urandom_range(3) != 0) b = ~b;
    byte_stream.push_back(b);
  endfunction

  function automatic void random_payload(int n);
    repeat (n) payload_q.push_back(8'($urandom_range(255)));
  endfunction

  // Build a complete frame around payload_q, with a good or a corrupted checksum.
  function automatic void append_frame(logic [7:0] type_byte, bit good);
    logic [15:0] len;
    logic [7:0]  sum;
    len = 16'(payload_q.size() + 1);
    sum = type_byte;
    queue_byte(cur_delim);
    queue_byte(len[15:8]);
    queue_byte(len[7:0]);
    queue_byte(type_byte);
    foreach (payload_q[i]) begin
      queue_byte(payload_q[i]);
      sum = sum + payload_q[i];
    end
    if (good) queue_byte(SUM_GOOD - sum);
    else queue_byte((SUM_GOOD - sum) ^ 8'($urandom_range(1, 255)));
    payload_q.delete();
  endfunction

  function automatic void append_zero_len();
    queue_byte(cur_delim);
    queue_byte(8'h00);
    queue_byte(8'h00);
  endfunction

  // Header with an unknown type byte; the frame ends on the type byte.
  function automatic void append_unknown(logic [15:0] len);
    logic [7:0]         b;
    logic [FTYPE_W-1:0] c;
    do b = 8'($urandom_range(255)); while (decode_type(b, c));
    if (len == 16'd0) len = 16'd1;
    queue_byte(cur_delim);
    queue_byte(len[15:8]);
    queue_byte(len[7:0]);
    queue_byte(b);
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Offer one byte and hold it until the block takes it.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic flush_stream();
    while (byte_stream.size() != 0) send_byte(byte_stream.pop_front());
  endtask

  // Stop sending until every owed result has come out, then let the pipe settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_delimiter(logic [7:0] v);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tracker.set_delimiter(v);
    cur_delim = v;
  endtask

  // Mostly well-formed frames with random content, salted with broken ones and noise.
  task automatic random_traffic(int budget);
    int start;
    int r;
    start = frame_bytes;
    while (frame_bytes - start < budget) begin
      r = $urandom_range(99);
      if (r < 62) begin
        random_payload(($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(8, 40));
        append_frame(known_types[$urandom_range(4)], $urandom_range(3) != 0);
      end else if (r < 70) begin
        append_zero_len();
      end else if (r < 79) begin
        // Any length, the type byte cuts the frame short; the tail is noise.
        append_unknown(16'($urandom_range(16'hFFFF)));
        repeat ($urandom_range(3)) queue_noise();
      end else if (r < 87) begin
        // Truncated frame: the next frame's bytes get swallowed as payload.
        queue_byte(cur_delim);
        queue_byte(8'h00);
        queue_byte(8'($urandom_range(2, 9)));
        queue_byte(known_types[$urandom_range(4)]);
        repeat ($urandom_range(2)) queue_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 4)) queue_noise();
      end
      flush_stream();
      if ($urandom_range(9) == 0) drain_results();
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    cfg_we   = 1'b0;
    cfg_data = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames on the reset delimiter.
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'hFF);
    append_zero_len();
    append_frame(TB_TX_STATUS, 1'b1);            // length one, good sum
    payload_q.push_back(8'h00);
    payload_q.push_back(8'hFF);
    append_frame(TB_ZB_TX_STATUS, 1'b0);         // bad sum
    append_unknown(16'h0003);
    append_frame(TB_ZB_RECEIVE, 1'b1);
    flush_stream();
    drain_results();

    delim_plan[2] = 8'($urandom_range(1, 254));
    foreach (delim_plan[p]) begin
      // Leave a frame open so the new delimiter lands mid-frame.
      if (p == 3) begin
        queue_byte(cur_delim);
        queue_byte(8'h00);
        queue_byte(8'h04);
        queue_byte(TB_RX64);
        queue_byte(8'($urandom_range(255)));
        flush_stream();
      end
      write_delimiter(delim_plan[p]);
      tx_steady = (p == 1) || ($urandom_range(3) == 0);
      rx_steady = (p == 1) || ($urandom_range(3) == 0);
      // One long frame so the high length byte and index bits get used.
      if (p == 2) begin
        random_payload(259);
        append_frame(TB_RX16, 1'b1);
        flush_stream();
      end
      random_traffic(75);
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d frame bytes under six delimiter values, %0d results checked",
             frame_bytes, tracker.checked);
    $display("Frame ends: %0d ok, %0d unknown type, %0d bad checksum, %0d zero length",
             tracker.ends_seen[ST_OK], tracker.ends_seen[ST_UNKNOWN],
             tracker.ends_seen[ST_BADSUM], tracker.ends_seen[ST_ZEROLEN]);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
